// ===== rtl/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

    localparam int TickWidth    = 16;
    localparam int RetryWidth   = 8;
    localparam int ByteWidth    = 8;
    localparam int KindWidth    = 3;
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 16;

    localparam logic [TickWidth-1:0]  HALF_PERIOD_RESET = 16'd4;
    localparam logic [RetryWidth-1:0] RETRY_LIMIT_RESET = 8'd200;
    localparam logic [TickWidth-1:0]  RETRY_WAIT_RESET  = 16'd1000;

    localparam logic [CfgIdxWidth-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_RETRY_WAIT  = 2'd2;

    typedef enum logic [KindWidth-1:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WACK  = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [TickWidth-1:0]  half_period;
        logic [RetryWidth-1:0] retry_limit;
        logic [TickWidth-1:0]  retry_wait;
    } cfg_t;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 busy;
        logic                 done;
        logic [ByteWidth-1:0] read_value;
        logic                 ack_seen;
    } result_t;

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// channel   ports                                            direction
// s_        s_valid s_ready s_kind s_write_value             in
//           s_give_ack s_sda_sample
// m_        m_valid m_ready m_scl_level m_sda_level          out
//           m_busy_res m_done_res m_read_value m_ack_seen
// cfg_      cfg_valid cfg_ready cfg_index cfg_data           in
//
// one tick transaction per clock while s_ready is high, one result per tick, registered
// sequencer step is a single pass of logic from the state registers to the result register
// aresetn synchronous active low: idle, both lines released, config at defaults
// a stall on m_ blocks s_ only while the result register is full and not taken
// cfg_ready is always high

module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [KindWidth-1:0]    s_kind,
    input  logic [ByteWidth-1:0]    s_write_value,
    input  logic                    s_give_ack,
    input  logic                    s_sda_sample,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_scl_level,
    output logic                    m_sda_level,
    output logic                    m_busy_res,
    output logic                    m_done_res,
    output logic [ByteWidth-1:0]    m_read_value,
    output logic                    m_ack_seen,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t step_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period <= HALF_PERIOD_RESET;
            cfg_reg.retry_limit <= RETRY_LIMIT_RESET;
            cfg_reg.retry_wait  <= RETRY_WAIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HALF_PERIOD: cfg_reg.half_period <= cfg_data[TickWidth-1:0];
                REG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_data[RetryWidth-1:0];
                REG_RETRY_WAIT:  cfg_reg.retry_wait  <= cfg_data[TickWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    i2cmbe_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (in_accept),
        .kind        (s_kind),
        .write_value (s_write_value),
        .give_ack    (s_give_ack),
        .sda_sample  (s_sda_sample),
        .cfg         (cfg_reg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_scl_level  = out_reg.scl_level;
    assign m_sda_level  = out_reg.sda_level;
    assign m_busy_res   = out_reg.busy;
    assign m_done_res   = out_reg.done;
    assign m_read_value = out_reg.read_value;
    assign m_ack_seen   = out_reg.ack_seen;

endmodule

// ===== rtl/i2cmbe_core.sv =====
module i2cmbe_core
    import i2cmbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [KindWidth-1:0] kind,
    input  logic [ByteWidth-1:0] write_value,
    input  logic                 give_ack,
    input  logic                 sda_sample,
    input  cfg_t                 cfg,
    output result_t              result
);

    localparam logic [1:0] PHASE_FIRST    = 2'd0;
    localparam logic [1:0] PHASE_SECOND   = 2'd1;
    localparam logic [1:0] PHASE_ACK_LOW  = 2'd2;
    localparam logic [1:0] PHASE_ACK_HIGH = 2'd3;

    cmd_t                  cmd_reg, cmd_next;
    logic [1:0]            phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [ByteWidth-1:0]  shift_reg, shift_next;
    logic [TickWidth-1:0]  tick_reg, tick_next;
    logic [RetryWidth-1:0] poll_reg, poll_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  ack_flag_reg, ack_flag_next;
    logic                  ack_send_reg, ack_send_next;
    logic [ByteWidth-1:0]  read_byte_reg, read_byte_next;

    logic [TickWidth-1:0]  len_raw;
    logic [TickWidth-1:0]  phase_len;
    logic                  phase_end;
    logic                  kind_ok;
    logic [3:0]            bit_inc;
    logic [ByteWidth-1:0]  shift_left;
    logic                  done;

    assign len_raw   = (cmd_reg == CMD_WACK && phase_reg == PHASE_SECOND) ?
                       cfg.retry_wait : cfg.half_period;
    assign phase_len = (len_raw == '0) ? TickWidth'(1) : len_raw;
    assign phase_end = tick_reg >= phase_len;
    assign kind_ok   = kind >= CMD_START && kind <= CMD_WACK;
    assign bit_inc   = bit_count_reg + 4'd1;
    assign shift_left = {shift_reg[ByteWidth-2:0], 1'b0};

    always_comb begin
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        poll_next      = poll_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_flag_next  = ack_flag_reg;
        ack_send_next  = ack_send_reg;
        read_byte_next = read_byte_reg;
        done           = 1'b0;

        if (cmd_reg == CMD_IDLE) begin
            if (kind_ok) begin
                cmd_next       = cmd_t'(kind);
                bit_count_next = '0;
                poll_next      = '0;
                phase_next     = PHASE_FIRST;
                tick_next      = TickWidth'(1);
                scl_next       = 1'b1;
                sda_next       = 1'b1;
                unique case (cmd_t'(kind))
                    CMD_STOP: begin
                        sda_next = 1'b0;
                    end
                    CMD_WRITE: begin
                        shift_next = write_value;
                        scl_next   = 1'b0;
                        sda_next   = write_value[ByteWidth-1];
                    end
                    CMD_READ: begin
                        shift_next    = '0;
                        ack_send_next = give_ack;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (phase_end) begin
            unique case (cmd_reg)
                CMD_START: begin
                    if (phase_reg == PHASE_FIRST) begin
                        sda_next   = 1'b0;
                        phase_next = PHASE_SECOND;
                        tick_next  = TickWidth'(1);
                    end else begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (phase_reg == PHASE_FIRST) begin
                        sda_next   = 1'b1;
                        phase_next = PHASE_SECOND;
                        tick_next  = TickWidth'(1);
                    end else begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (phase_reg == PHASE_FIRST) begin
                        scl_next   = 1'b1;
                        phase_next = PHASE_SECOND;
                        tick_next  = TickWidth'(1);
                    end else begin
                        shift_next     = shift_left;
                        bit_count_next = bit_inc;
                        scl_next       = 1'b0;
                        if (bit_inc[3]) begin
                            done = 1'b1;
                        end else begin
                            sda_next   = shift_left[ByteWidth-1];
                            phase_next = PHASE_FIRST;
                            tick_next  = TickWidth'(1);
                        end
                    end
                end
                CMD_READ: begin
                    unique case (phase_reg)
                        PHASE_FIRST: begin
                            shift_next = {shift_reg[ByteWidth-2:0], sda_sample};
                            scl_next   = 1'b0;
                            phase_next = PHASE_SECOND;
                            tick_next  = TickWidth'(1);
                        end
                        PHASE_SECOND: begin
                            bit_count_next = bit_inc;
                            tick_next      = TickWidth'(1);
                            if (bit_inc[3]) begin
                                scl_next   = 1'b0;
                                sda_next   = ~ack_send_reg;
                                phase_next = PHASE_ACK_LOW;
                            end else begin
                                scl_next   = 1'b1;
                                phase_next = PHASE_FIRST;
                            end
                        end
                        PHASE_ACK_LOW: begin
                            scl_next   = 1'b1;
                            phase_next = PHASE_ACK_HIGH;
                            tick_next  = TickWidth'(1);
                        end
                        default: begin
                            scl_next       = 1'b0;
                            read_byte_next = shift_reg;
                            done           = 1'b1;
                        end
                    endcase
                end
                default: begin
                    if (poll_reg < cfg.retry_limit) begin
                        if (!sda_sample) begin
                            ack_flag_next = 1'b1;
                            scl_next      = 1'b0;
                            done          = 1'b1;
                        end else begin
                            poll_next  = poll_reg + RetryWidth'(1);
                            phase_next = PHASE_SECOND;
                            tick_next  = TickWidth'(1);
                        end
                    end else begin
                        ack_flag_next = 1'b0;
                        scl_next      = 1'b0;
                        done          = 1'b1;
                    end
                end
            endcase
            if (done) begin
                cmd_next   = CMD_IDLE;
                phase_next = PHASE_FIRST;
                tick_next  = '0;
            end
        end else begin
            tick_next = tick_reg + TickWidth'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_IDLE;
            phase_reg     <= PHASE_FIRST;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            tick_reg      <= '0;
            poll_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_flag_reg  <= 1'b0;
            ack_send_reg  <= 1'b0;
            read_byte_reg <= '0;
        end else if (step_en) begin
            cmd_reg       <= cmd_next;
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            poll_reg      <= poll_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_flag_reg  <= ack_flag_next;
            ack_send_reg  <= ack_send_next;
            read_byte_reg <= read_byte_next;
        end
    end

    assign result.scl_level  = scl_next;
    assign result.sda_level  = sda_next;
    assign result.busy       = cmd_next != CMD_IDLE;
    assign result.done       = done;
    assign result.read_value = read_byte_next;
    assign result.ack_seen   = ack_flag_next;

`ifndef ASSERT_OFF
    a_busy_tick_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg != CMD_IDLE |-> tick_reg != '0)
        else $error("active command with zero tick count");

    a_write_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg == CMD_WRITE |-> !bit_count_reg[3])
        else $error("write still active after eight bits");

    a_ack_phase_read_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PHASE_ACK_LOW || phase_reg == PHASE_ACK_HIGH) |-> cmd_reg == CMD_READ)
        else $error("ack phase outside a read");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && done |=> cmd_reg == CMD_IDLE && phase_reg == PHASE_FIRST)
        else $error("command did not return to idle after done");
`endif

endmodule
